/* design/vkt_pkg.sv */
// Package for the versioned key table: field widths, status and opcode codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package vkt_pkg;

  localparam int KEY_W    = 32;
  localparam int VER_W    = 31;
  localparam int PAY_IN_W = 64;
  localparam int STAT_W   = 2;
  localparam int RCNT_W   = 7;

  localparam logic [VER_W-1:0] VER_MAX = {VER_W{1'b1}};

  // Opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NONE     = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

  // Controller to datapath
  typedef struct packed {
    logic req_load;   // capture request, clear accumulators
    logic clr_wr;     // write an empty slot at the sweep address
    logic scan_rd;    // read slot at the sweep address
    logic cnt_inc;    // advance sweep address
    logic cnt_clr;    // rewind sweep address
    logic commit_wr;  // store an inserted entry if the insert succeeds
    logic out_load;   // load the result register
  } vkt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_last;   // sweep address is at the last slot
    logic out_free;   // result register can take a new result
  } vkt_sts_t;

endpackage

/* design/vkt_ctrl.sv */
// Controller state machine of the versioned key table.
// Depends on vkt_pkg for the command and status structs.
module vkt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  vkt_pkg::vkt_sts_t sts_i,
  output vkt_pkg::vkt_cmd_t cmd_o
);
  import vkt_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.cnt_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_DRAIN;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        cmd_o.commit_wr = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state; start with the clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* design/vkt_datapath.sv */
// Datapath of the versioned key table: slot memory, sweep counter, scan
// accumulators, request register and result register. Depends on vkt_pkg.
module vkt_datapath #(
  parameter int TABLE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vkt_pkg::vkt_cmd_t             cmd_i,
  output vkt_pkg::vkt_sts_t             sts_o,
  input  logic                          opcode_i,
  input  logic [vkt_pkg::KEY_W-1:0]     key_i,
  input  logic [vkt_pkg::VER_W-1:0]     version_i,
  input  logic [vkt_pkg::PAY_IN_W-1:0]  payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vkt_pkg::STAT_W-1:0]    status_o,
  output logic [vkt_pkg::VER_W-1:0]     assigned_version_o,
  output logic [vkt_pkg::RCNT_W-1:0]    removed_count_o
);
  import vkt_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int RC_W  = (CNT_W > RCNT_W) ? CNT_W : RCNT_W;

  // Slot memory
  logic                    mem_valid [TABLE_DEPTH];
  logic [KEY_W-1:0]        mem_key   [TABLE_DEPTH];
  logic [VER_W-1:0]        mem_ver   [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] mem_pay   [TABLE_DEPTH];

  // Sweep address
  logic [IDX_W-1:0] cnt_q;

  // Request
  logic                    req_op_q;
  logic [KEY_W-1:0]        req_key_q;
  logic [VER_W-1:0]        req_ver_q;
  logic [PAYLOAD_BITS-1:0] req_pay_q;

  // Read stage
  logic             chk_v_q;
  logic [IDX_W-1:0] chk_addr_q;
  logic             rd_valid_q;
  logic [KEY_W-1:0] rd_key_q;
  logic [VER_W-1:0] rd_ver_q;

  // Accumulators
  logic [VER_W-1:0] newest_q, newest_d;
  logic             free_found_q, free_found_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;
  logic [RC_W-1:0]  removed_q, removed_d;
  logic             del_hit_q, del_hit_d;
  logic             del_wr;

  // Result
  logic              ins_ok;
  logic [VER_W-1:0]  next_ver;
  logic [STAT_W-1:0] res_status;
  logic [VER_W-1:0]  res_assigned;
  logic [RCNT_W-1:0] res_removed;

  // Write port
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_valid;

  logic              out_valid_q;
  logic [STAT_W-1:0] status_q;
  logic [VER_W-1:0]  assigned_q;
  logic [RCNT_W-1:0] removed_out_q;

  assign sts_o.cnt_last = (cnt_q == IDX_W'(TABLE_DEPTH - 1));
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  // Advance or rewind the sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_clr) begin
      cnt_q <= '0;
    end else if (cmd_i.cnt_inc) begin
      cnt_q <= cnt_q + IDX_W'(1);
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_op_q  <= opcode_i;
      req_key_q <= key_i;
      req_ver_q <= version_i;
      req_pay_q <= payload_i[PAYLOAD_BITS-1:0];
    end
  end

  // Read one slot per cycle during the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan_rd) begin
      rd_valid_q <= mem_valid[cnt_q];
      rd_key_q   <= mem_key[cnt_q];
      rd_ver_q   <= mem_ver[cnt_q];
      chk_addr_q <= cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_v_q <= 1'b0;
    end else begin
      chk_v_q <= cmd_i.scan_rd;
    end
  end

  // Examine the slot just read
  always_comb begin
    logic key_hit;
    key_hit      = rd_valid_q && (rd_key_q == req_key_q);
    newest_d     = newest_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    removed_d    = removed_q;
    del_hit_d    = del_hit_q;
    del_wr       = 1'b0;
    if (chk_v_q) begin
      if (req_op_q == OP_INSERT) begin
        if (key_hit && (rd_ver_q > newest_q)) begin
          newest_d = rd_ver_q;
        end
        if (!rd_valid_q && !free_found_q) begin
          free_found_d = 1'b1;
          free_idx_d   = chk_addr_q;
        end
      end else if (key_hit) begin
        if (req_ver_q == '0) begin
          del_wr    = 1'b1;
          removed_d = removed_q + RC_W'(1);
        end else if (!del_hit_q && (rd_ver_q == req_ver_q)) begin
          del_wr    = 1'b1;
          del_hit_d = 1'b1;
          removed_d = RC_W'(1);
        end
      end
    end
  end

  // Hold accumulators; clear them when a request is taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      newest_q     <= '0;
      free_found_q <= 1'b0;
      free_idx_q   <= '0;
      removed_q    <= '0;
      del_hit_q    <= 1'b0;
    end else begin
      newest_q     <= newest_d;
      free_found_q <= free_found_d;
      free_idx_q   <= free_idx_d;
      removed_q    <= removed_d;
      del_hit_q    <= del_hit_d;
    end
  end

  // Form the result
  assign next_ver = newest_q + VER_W'(1);
  assign ins_ok   = (newest_q != VER_MAX) && free_found_q;

  always_comb begin
    res_status   = ST_OK;
    res_assigned = '0;
    res_removed  = '0;
    if (req_op_q == OP_INSERT) begin
      if (newest_q == VER_MAX) begin
        res_status = ST_OVERFLOW;
      end else if (!free_found_q) begin
        res_status = ST_FULL;
      end else begin
        res_assigned = next_ver;
      end
    end else begin
      res_removed = removed_q[RCNT_W-1:0];
      if (removed_q == '0) begin
        res_status = ST_NONE;
      end
    end
  end

  // Select the write port source
  always_comb begin
    wr_en    = 1'b0;
    wr_addr  = cnt_q;
    wr_valid = 1'b0;
    if (cmd_i.clr_wr) begin
      wr_en = 1'b1;
    end else if (del_wr) begin
      wr_en   = 1'b1;
      wr_addr = chk_addr_q;
    end else if (cmd_i.commit_wr && (req_op_q == OP_INSERT) && ins_ok) begin
      wr_en    = 1'b1;
      wr_addr  = free_idx_q;
      wr_valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_valid[wr_addr] <= wr_valid;
      mem_key[wr_addr]   <= req_key_q;
      mem_ver[wr_addr]   <= next_ver;
      mem_pay[wr_addr]   <= req_pay_q;
    end
  end

  // Result register: load on command, drop on acceptance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q      <= res_status;
      assigned_q    <= res_assigned;
      removed_out_q <= res_removed;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign assigned_version_o = assigned_q;
  assign removed_count_o    = removed_out_q;

endmodule

/* design/versioned_key_table_unit.sv */
// Top level of the versioned key table: controller plus datapath.
// Depends on vkt_pkg, vkt_ctrl and vkt_datapath.
//
//   channel   handshake                  payload
//   request   in_valid_i / in_ready_o    opcode_i, key_i, version_i, payload_i
//   result    out_valid_o / out_ready_i  status_o, assigned_version_o, removed_count_o
//
// Each request scans every slot once through the single read port of the
// slot memory, one slot per cycle; the next request is accepted only after
// the scan, commit and result load of the previous one.
// After reset a clearing sweep empties the table; no request is taken during it.
// A result waiting in the output register does not block the next request;
// only the load of a new result waits for the previous one to be taken.
module versioned_key_table_unit #(
  parameter int TABLE_DEPTH  = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          opcode_i,
  input  logic [vkt_pkg::KEY_W-1:0]     key_i,
  input  logic [vkt_pkg::VER_W-1:0]     version_i,
  input  logic [vkt_pkg::PAY_IN_W-1:0]  payload_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [vkt_pkg::STAT_W-1:0]    status_o,
  output logic [vkt_pkg::VER_W-1:0]     assigned_version_o,
  output logic [vkt_pkg::RCNT_W-1:0]    removed_count_o
);
  import vkt_pkg::*;

  vkt_cmd_t cmd;
  vkt_sts_t sts;

  vkt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  vkt_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .opcode_i           (opcode_i),
    .key_i              (key_i),
    .version_i          (version_i),
    .payload_i          (payload_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .status_o           (status_o),
    .assigned_version_o (assigned_version_o),
    .removed_count_o    (removed_count_o)
  );

endmodule

/* design/vkt_checker.sv */
// Port-level checks for the versioned key table, bound to the top level.
// Depends on vkt_pkg and versioned_key_table_unit.
module vkt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [vkt_pkg::STAT_W-1:0] status_o,
  input logic [vkt_pkg::VER_W-1:0]  assigned_version_o,
  input logic [vkt_pkg::RCNT_W-1:0] removed_count_o
);
  import vkt_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(assigned_version_o) && $stable(removed_count_o))
    else $error("stalled result changed");

  // One request at a time: no request right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken during a scan");

  // Failed requests report no version and no count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_OVERFLOW
      || status_o == ST_NONE) |-> assigned_version_o == '0 && removed_count_o == '0)
    else $error("failed request reports version or count");

  // A granted version belongs to a successful insert
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && assigned_version_o != '0 |-> status_o == ST_OK
      && removed_count_o == '0)
    else $error("version given with wrong status or count");

endmodule

bind versioned_key_table_unit vkt_checker u_vkt_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .status_o           (status_o),
  .assigned_version_o (assigned_version_o),
  .removed_count_o    (removed_count_o)
);
